>>> rtl/core/rdz_pkg.sv
// Shared constants and types for the radial dead zone unit.
package rdz_pkg;
   localparam int SampleWidth = 16;
   localparam int FracBits    = SampleWidth - 1;
   localparam int SqWidth     = 2 * SampleWidth;       // x*x + y*y
   localparam int MagWidth    = SampleWidth;           // floor(sqrt) fits
   localparam int NormWidth   = SampleWidth;           // 0 .. ONE
   localparam int QuoWidth    = MagWidth + 1;          // norm quotient bits needed
   localparam int ProdWidth   = SampleWidth + NormWidth;
   localparam int DivWidth    = ProdWidth;
   localparam int RootSteps   = SampleWidth;
   localparam logic [SampleWidth-1:0] FullOne = SampleWidth'(1) << FracBits;

   localparam int CfgIdxWidth = 1;
   localparam logic [CfgIdxWidth-1:0] RegInner = 1'b0;
   localparam logic [CfgIdxWidth-1:0] RegOuter = 1'b1;

   typedef logic [FracBits-1:0] zone_type;

   // Everything one sample carries down the cell row.
   typedef struct packed {
      logic                   valid;
      logic                   x_neg;
      logic                   y_neg;
      logic [SampleWidth-1:0] ax;
      logic [SampleWidth-1:0] ay;
      logic [SqWidth-1:0]     rem;    // root remainder / scratch
      logic [MagWidth-1:0]    mag;
      logic [NormWidth-1:0]   norm;
      logic                   zero;
      zone_type               inner;
      zone_type               outer;
   } lane_type;
endpackage

>>> rtl/core/rdz_root_cell.sv
// One restoring square-root cell: resolves one magnitude bit per stage.
module rdz_root_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  rdz_pkg::lane_type up_in,
   input  logic [4:0]        bit_pos,
   output rdz_pkg::lane_type dn_out
);
   import rdz_pkg::*;
   lane_type lane_ff, lane_in;
   logic [SqWidth+1:0] trial;

   always_comb begin
      lane_in = up_in;
      // trial = (2*res + 1) << 2*bit_pos against remaining radicand
      trial = ({{(SqWidth+2-MagWidth){1'b0}}, up_in.mag} << (bit_pos + 5'd1))
            | ((SqWidth+2)'(1) << {bit_pos, 1'b0});
      if ({2'b00, up_in.rem} >= trial) begin
         lane_in.rem = up_in.rem - trial[SqWidth-1:0];
         lane_in.mag = up_in.mag | (MagWidth'(1) << bit_pos);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) lane_ff.valid <= 1'b0;
      else if (step_en) lane_ff.valid <= lane_in.valid;
      if (step_en) begin
         lane_ff.x_neg <= lane_in.x_neg; lane_ff.y_neg <= lane_in.y_neg;
         lane_ff.ax <= lane_in.ax; lane_ff.ay <= lane_in.ay;
         lane_ff.rem <= lane_in.rem; lane_ff.mag <= lane_in.mag;
         lane_ff.norm <= lane_in.norm; lane_ff.zero <= lane_in.zero;
         lane_ff.inner <= lane_in.inner; lane_ff.outer <= lane_in.outer;
      end
   end
   assign dn_out = lane_ff;
endmodule

>>> rtl/core/rdz_div_cell.sv
// One restoring divider cell: one quotient bit per stage, remainder passed on.
module rdz_div_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step_en,
   input  logic                              vld_in,
   input  logic [rdz_pkg::DivWidth-1:0]      num_in,  // remaining dividend bits
   input  logic [rdz_pkg::DivWidth-1:0]      rem_in,
   input  logic [rdz_pkg::DivWidth-1:0]      quo_in,
   input  logic [rdz_pkg::DivWidth-1:0]      den_in,
   input  logic [rdz_pkg::SampleWidth*2-1:0] side_in, // passenger data
   output logic                              vld_out,
   output logic [rdz_pkg::DivWidth-1:0]      num_out,
   output logic [rdz_pkg::DivWidth-1:0]      rem_out,
   output logic [rdz_pkg::DivWidth-1:0]      quo_out,
   output logic [rdz_pkg::DivWidth-1:0]      den_out,
   output logic [rdz_pkg::SampleWidth*2-1:0] side_out
);
   import rdz_pkg::*;
   logic [DivWidth:0] shifted;
   logic [DivWidth-1:0] rem_in2, quo_in2;
   logic vld_ff;
   logic [DivWidth-1:0] num_ff, rem_ff, quo_ff, den_ff;
   logic [SampleWidth*2-1:0] side_ff;

   always_comb begin
      shifted = {rem_in, num_in[DivWidth-1]};
      if (shifted >= {1'b0, den_in}) begin
         rem_in2 = DivWidth'(shifted - {1'b0, den_in});
         quo_in2 = {quo_in[DivWidth-2:0], 1'b1};
      end else begin
         rem_in2 = shifted[DivWidth-1:0];
         quo_in2 = {quo_in[DivWidth-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else if (step_en) vld_ff <= vld_in;
      if (step_en) begin
         num_ff <= {num_in[DivWidth-2:0], 1'b0};
         rem_ff <= rem_in2; quo_ff <= quo_in2;
         den_ff <= den_in; side_ff <= side_in;
      end
   end
   assign vld_out = vld_ff; assign num_out = num_ff; assign rem_out = rem_ff;
   assign quo_out = quo_ff; assign den_out = den_ff; assign side_out = side_ff;
endmodule

>>> rtl/core/rdz_div_row.sv
// A row of divider cells: unsigned num / den, full-width quotient.
module rdz_div_row (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step_en,
   input  logic                              vld_in,
   input  logic [rdz_pkg::DivWidth-1:0]      num_in,
   input  logic [rdz_pkg::DivWidth-1:0]      den_in,
   input  logic [rdz_pkg::SampleWidth*2-1:0] side_in,
   output logic                              vld_out,
   output logic [rdz_pkg::DivWidth-1:0]      quo_out,
   output logic [rdz_pkg::SampleWidth*2-1:0] side_out
);
   import rdz_pkg::*;
   logic                     v  [DivWidth+1];
   logic [DivWidth-1:0]      n  [DivWidth+1];
   logic [DivWidth-1:0]      r  [DivWidth+1];
   logic [DivWidth-1:0]      q  [DivWidth+1];
   logic [DivWidth-1:0]      d  [DivWidth+1];
   logic [SampleWidth*2-1:0] s  [DivWidth+1];

   assign v[0] = vld_in; assign n[0] = num_in; assign r[0] = '0;
   assign q[0] = '0; assign d[0] = den_in; assign s[0] = side_in;

   for (genvar i = 0; i < DivWidth; i++) begin : g_cell
      rdz_div_cell u_cell (
         .clock, .reset, .step_en,
         .vld_in(v[i]), .num_in(n[i]), .rem_in(r[i]), .quo_in(q[i]),
         .den_in(d[i]), .side_in(s[i]),
         .vld_out(v[i+1]), .num_out(n[i+1]), .rem_out(r[i+1]),
         .quo_out(q[i+1]), .den_out(d[i+1]), .side_out(s[i+1])
      );
   end
   assign vld_out = v[DivWidth]; assign quo_out = q[DivWidth];
   assign side_out = s[DivWidth];
endmodule

>>> rtl/core/radial_dead_zone_unit.sv
// Top level of the radial dead zone unit.
// Usage:
//  Samples enter on req_ (req_stick_x/req_stick_y, signed Q1.15) under
//  valid/ready; each gives exactly one beat on rsp_ (rsp_shaped_x/y).
//  The pipeline is a chain of cells: 2 squaring/entry stages, 16 square-root
//  cells (one magnitude bit each), 32 divider cells for the normalized
//  magnitude, a multiply stage, 32 divider cells per axis (both axes run in
//  parallel rows), then a saturation stage. Throughput is one sample per clock
//  while the output is not stalled, set by the one-bit-per-cell root and divide rows.
//  The whole chain advances only when the output register is empty or being
//  taken, so a stalled receiver freezes all cells and req_ready drops; no beat
//  is lost. Zones come from csr_ writes (index 0 inner, 1 outer), sampled into
//  each beat at entry; write them only while idle.
//  Synchronous active-high reset empties the pipeline and restores the zones
//  to 3277 and 1638.
module radial_dead_zone_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [rdz_pkg::SampleWidth-1:0] req_stick_x,
   input  logic signed [rdz_pkg::SampleWidth-1:0] req_stick_y,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [rdz_pkg::SampleWidth-1:0] rsp_shaped_x,
   output logic signed [rdz_pkg::SampleWidth-1:0] rsp_shaped_y,
   input  logic                              csr_write,
   input  logic [rdz_pkg::CfgIdxWidth-1:0]   csr_index,
   input  logic [rdz_pkg::FracBits-1:0]      csr_data
);
   import rdz_pkg::*;

   zone_type inner_ff, outer_ff;
   logic step_en;
   logic out_vld_ff;
   logic [SampleWidth-1:0] out_x_ff, out_y_ff;

   assign step_en   = !out_vld_ff || rsp_ready;
   assign req_ready = step_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         inner_ff <= FracBits'(3277);
         outer_ff <= FracBits'(1638);
      end else if (csr_write) begin
         unique case (csr_index)
            RegInner: inner_ff <= csr_data;
            RegOuter: outer_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // entry: absolute values and squares
   lane_type e0_ff, e1_ff;
   logic [SampleWidth-1:0] ax_in, ay_in;
   assign ax_in = req_stick_x[SampleWidth-1] ? SampleWidth'(-req_stick_x) : req_stick_x;
   assign ay_in = req_stick_y[SampleWidth-1] ? SampleWidth'(-req_stick_y) : req_stick_y;
   logic [SqWidth-1:0] sqx_ff, sqy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e0_ff.valid <= 1'b0; e1_ff.valid <= 1'b0;
      end else if (step_en) begin
         e0_ff.valid <= req_valid; e1_ff.valid <= e0_ff.valid;
      end
      if (step_en) begin
         e0_ff.x_neg <= req_stick_x[SampleWidth-1];
         e0_ff.y_neg <= req_stick_y[SampleWidth-1];
         e0_ff.ax <= ax_in; e0_ff.ay <= ay_in;
         e0_ff.rem <= '0; e0_ff.mag <= '0; e0_ff.norm <= '0; e0_ff.zero <= 1'b0;
         e0_ff.inner <= inner_ff; e0_ff.outer <= outer_ff;
         sqx_ff <= ax_in * ax_in; sqy_ff <= ay_in * ay_in;
         e1_ff.x_neg <= e0_ff.x_neg; e1_ff.y_neg <= e0_ff.y_neg;
         e1_ff.ax <= e0_ff.ax; e1_ff.ay <= e0_ff.ay;
         e1_ff.rem <= sqx_ff + sqy_ff;  // max 2^31, fits
         e1_ff.mag <= '0; e1_ff.norm <= '0; e1_ff.zero <= 1'b0;
         e1_ff.inner <= e0_ff.inner; e1_ff.outer <= e0_ff.outer;
      end
   end

   // square-root row, MSB first
   lane_type rt [RootSteps+1];
   assign rt[0] = e1_ff;
   for (genvar i = 0; i < RootSteps; i++) begin : g_root
      rdz_root_cell u_root (
         .clock, .reset, .step_en, .up_in(rt[i]),
         .bit_pos(5'(RootSteps - 1 - i)), .dn_out(rt[i+1])
      );
   end

   // normalized magnitude: ((m - inner) << F) / range
   lane_type rr;
   logic signed [SampleWidth+1:0] range_s;
   logic wide_open, below;
   logic [DivWidth-1:0] n_num, n_den;
   assign rr = rt[RootSteps];
   assign range_s = $signed({2'b00, FullOne}) - $signed({3'b000, rr.outer})
                  - $signed({3'b000, rr.inner});
   assign below = rr.mag <= {1'b0, rr.inner};
   assign wide_open = range_s <= 0;
   assign n_num = below ? '0 : DivWidth'({rr.mag - {1'b0, rr.inner}, {FracBits{1'b0}}});
   assign n_den = wide_open ? DivWidth'(1) : DivWidth'(range_s[SampleWidth-1:0]);

   // passenger: ax, ay; mag/flags travel on a side shift line
   logic n_vld;
   logic [DivWidth-1:0] n_quo;
   logic [SampleWidth*2-1:0] n_side;
   logic [MagWidth+3-1:0] ln_ff [DivWidth];
   rdz_div_row u_norm (
      .clock, .reset, .step_en, .vld_in(rr.valid), .num_in(n_num), .den_in(n_den),
      .side_in({rr.ax, rr.ay}), .vld_out(n_vld), .quo_out(n_quo), .side_out(n_side)
   );
   always_ff @(posedge clock) begin
      if (step_en) begin
         ln_ff[0] <= {rr.mag, rr.x_neg, rr.y_neg, below | (wide_open & 1'b0)};
         for (int k = 1; k < DivWidth; k++) ln_ff[k] <= ln_ff[k-1];
      end
   end
   logic [MagWidth-1:0] ln_mag;
   logic ln_xn, ln_yn, ln_zero;
   assign {ln_mag, ln_xn, ln_yn, ln_zero} = ln_ff[DivWidth-1];
   logic wo_ff [DivWidth];
   always_ff @(posedge clock) begin
      if (step_en) begin
         wo_ff[0] <= wide_open;
         for (int k = 1; k < DivWidth; k++) wo_ff[k] <= wo_ff[k-1];
      end
   end

   // clamp and multiply by each axis
   logic [NormWidth-1:0] norm_c;
   assign norm_c = (wo_ff[DivWidth-1] || n_quo > DivWidth'(FullOne)) ? FullOne
                 : n_quo[NormWidth-1:0];
   logic m_vld_ff, m_xn_ff, m_yn_ff, m_zero_ff;
   logic [ProdWidth-1:0] px_ff, py_ff;
   logic [MagWidth-1:0] m_mag_ff;
   always_ff @(posedge clock) begin
      if (reset) m_vld_ff <= 1'b0;
      else if (step_en) m_vld_ff <= n_vld;
      if (step_en) begin
         px_ff <= n_side[SampleWidth*2-1:SampleWidth] * norm_c;
         py_ff <= n_side[SampleWidth-1:0] * norm_c;
         m_mag_ff <= ln_mag; m_xn_ff <= ln_xn; m_yn_ff <= ln_yn;
         m_zero_ff <= ln_zero;
      end
   end

   // per-axis divide by magnitude; guard zero divisor (only when zero flag set)
   logic [DivWidth-1:0] m_den;
   assign m_den = (m_mag_ff == '0) ? DivWidth'(1) : DivWidth'(m_mag_ff);
   logic ax_v, ay_v;
   logic [DivWidth-1:0] qx, qy;
   logic [SampleWidth*2-1:0] sx, sy;
   rdz_div_row u_divx (
      .clock, .reset, .step_en, .vld_in(m_vld_ff), .num_in(px_ff), .den_in(m_den),
      .side_in({{(SampleWidth*2-3){1'b0}}, m_xn_ff, m_yn_ff, m_zero_ff}),
      .vld_out(ax_v), .quo_out(qx), .side_out(sx)
   );
   rdz_div_row u_divy (
      .clock, .reset, .step_en, .vld_in(m_vld_ff), .num_in(py_ff), .den_in(m_den),
      .side_in('0), .vld_out(ay_v), .quo_out(qy), .side_out(sy)
   );

   function automatic logic [SampleWidth-1:0] sat_axis(
      input logic [DivWidth-1:0] q, input logic neg, input logic zero);
      logic [DivWidth-1:0] qc;
      begin
         qc = q;
         if (zero) return '0;
         if (neg) begin
            if (qc > DivWidth'(FullOne)) qc = DivWidth'(FullOne);
            return SampleWidth'(-qc[SampleWidth-1:0]);
         end
         if (qc > DivWidth'(FullOne) - 1) qc = DivWidth'(FullOne) - 1;
         return qc[SampleWidth-1:0];
      end
   endfunction

   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else if (step_en) out_vld_ff <= ax_v;
      if (step_en) begin
         out_x_ff <= sat_axis(qx, sx[2], sx[0]);
         out_y_ff <= sat_axis(qy, sx[1], sx[0] | (sy[0] & 1'b0));
      end
   end

   assign rsp_valid    = out_vld_ff;
   assign rsp_shaped_x = out_x_ff;
   assign rsp_shaped_y = out_y_ff;

   // both axis rows must stay in lockstep
   assert property (@(posedge clock) disable iff (reset) ax_v == ay_v)
      else $error("axis divider rows out of step");
   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_shaped_x) && $stable(rsp_shaped_y))
      else $error("stalled result changed");
   // no advance while the output register is held
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("accepted beat while stalled");
endmodule
